### src/ipid_pkg.sv
// Package for the incremental PID core with integral separation.
// Holds widths, register indexes, reset values and the shared structs.
// No dependencies; every other file imports it.
package ipid_pkg;

  // Speed field width; all error and product widths follow from it
  localparam int SPEED_WIDTH = 16;

  // Fixed widths of the configuration fields
  localparam int GAIN_W = 16;
  localparam int THR_W  = 16;
  localparam int DUTY_W = 10;

  // Error e, first difference and second difference
  localparam int ERR_W   = SPEED_WIDTH + 1;
  localparam int DIFF1_W = SPEED_WIDTH + 2;
  localparam int DIFF2_W = SPEED_WIDTH + 3;

  // Signed product of a zero-extended gain and the widest difference
  localparam int PROD_W = GAIN_W + 1 + DIFF2_W;
  // Three products plus the accumulated drive
  localparam int SUM_W  = PROD_W + 2;

  // Width used to compare |e| against the separation threshold
  localparam int CMP_W = (SPEED_WIDTH > THR_W) ? SPEED_WIDTH : THR_W;

  // APB port
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0]  SEP_THRESHOLD_RESET = 16'hFFFF;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET    = 10'd800;

  // Register index, taken from paddr word bits
  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEG    = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_SEP_THRESHOLD = 3'd3,
    REG_DUTY_LIMIT    = 3'd4
  } reg_idx_e;

  // Configuration register file contents
  typedef struct packed {
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
    logic [THR_W-1:0]  sep_threshold;
    logic [DUTY_W-1:0] duty_limit;
  } cfg_t;

  // Registered PID terms handed from the multiply stage to the accumulator
  typedef struct packed {
    logic signed [PROD_W-1:0] prop;
    logic signed [PROD_W-1:0] integ;
    logic signed [PROD_W-1:0] deriv;
  } prod_t;

endpackage

### src/incremental_pid_integral_separation_core.sv
// Top level of the incremental PID speed controller with integral separation.
// Depends on ipid_pkg, ipid_cfg, ipid_mult and ipid_accum.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries target_speed_i and
//   measured_speed_i; a transaction completes when valid is high and stall
//   low. Output channel (out_valid_o / out_stall_i) carries drive_duty_o,
//   one result per input transaction, in order.
//   Gains, separation threshold and duty limit are set over the APB port
//   (word addresses 0..4) while no transaction is in flight.
// Timing:
//   Three register stages: input register, multiply stage (error history
//   and the three products), accumulate stage (add, clamp, drive register).
//   One transaction per cycle sustained while out_stall_i is low; the drive
//   feedback loop is a single add and clamp inside the accumulate stage.
// Reset:
//   rst_ni clears the error history, the drive value and all stage valids;
//   configuration returns to gains 0, threshold 65535, duty limit 800.
// Stall:
//   A stalled output holds its value; the two stages behind it keep filling,
//   and in_stall_o rises only once all three stages hold a transaction.
module incremental_pid_integral_separation_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ipid_pkg::SPEED_WIDTH-1:0]   target_speed_i,
  input  logic [ipid_pkg::SPEED_WIDTH-1:0]   measured_speed_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ipid_pkg::DUTY_W-1:0]        drive_duty_o,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ipid_pkg::APB_AW-1:0]        paddr,
  input  logic [ipid_pkg::APB_DW-1:0]        pwdata,
  output logic [ipid_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import ipid_pkg::*;

  cfg_t                   cfg;
  prod_t                  prod;
  logic                   in_valid_q;
  logic [SPEED_WIDTH-1:0] target_q, measured_q;
  logic                   in_load;
  logic                   mult_ready, mult_valid, accum_ready;

  ipid_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register stage
  assign in_stall_o = in_valid_q && !mult_ready;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      target_q   <= target_speed_i;
      measured_q <= measured_speed_i;
    end
  end

  ipid_mult u_mult (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid_q),
    .target_speed_i   (target_q),
    .measured_speed_i (measured_q),
    .cfg_i            (cfg),
    .ready_o          (mult_ready),
    .valid_o          (mult_valid),
    .prod_o           (prod),
    .ready_i          (accum_ready)
  );

  ipid_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (mult_valid),
    .prod_i       (prod),
    .duty_limit_i (cfg.duty_limit),
    .ready_o      (accum_ready),
    .out_valid_o  (out_valid_o),
    .drive_duty_o (drive_duty_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

### src/ipid_cfg.sv
// APB configuration registers of the incremental PID core.
// Depends on ipid_pkg for register indexes, widths and reset values.
module ipid_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ipid_pkg::APB_AW-1:0]    paddr,
  input  logic [ipid_pkg::APB_DW-1:0]    pwdata,
  output logic [ipid_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output ipid_pkg::cfg_t                 cfg_o
);
  import ipid_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode the write transaction
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_GAIN_PROP:     cfg_d.gain_prop     = pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG:    cfg_d.gain_integ    = pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV:    cfg_d.gain_deriv    = pwdata[GAIN_W-1:0];
        REG_SEP_THRESHOLD: cfg_d.sep_threshold = pwdata[THR_W-1:0];
        REG_DUTY_LIMIT:    cfg_d.duty_limit    = pwdata[DUTY_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the register values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop     <= '0;
      cfg_q.gain_integ    <= '0;
      cfg_q.gain_deriv    <= '0;
      cfg_q.sep_threshold <= SEP_THRESHOLD_RESET;
      cfg_q.duty_limit    <= DUTY_LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register on a read
  always_comb begin
    case (idx)
      REG_GAIN_PROP:     prdata = APB_DW'(cfg_q.gain_prop);
      REG_GAIN_INTEG:    prdata = APB_DW'(cfg_q.gain_integ);
      REG_GAIN_DERIV:    prdata = APB_DW'(cfg_q.gain_deriv);
      REG_SEP_THRESHOLD: prdata = APB_DW'(cfg_q.sep_threshold);
      REG_DUTY_LIMIT:    prdata = APB_DW'(cfg_q.duty_limit);
      default:           prdata = '0;
    endcase
  end

endmodule

### src/ipid_mult.sv
// Error and multiply stage: forms e, keeps the two previous errors and
// registers the proportional, integral and derivative terms.
// Depends on ipid_pkg for widths and the cfg_t / prod_t structs.
module ipid_mult (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [ipid_pkg::SPEED_WIDTH-1:0]   target_speed_i,
  input  logic [ipid_pkg::SPEED_WIDTH-1:0]   measured_speed_i,
  input  ipid_pkg::cfg_t                     cfg_i,
  output logic                               ready_o,
  output logic                               valid_o,
  output ipid_pkg::prod_t                    prod_o,
  input  logic                               ready_i
);
  import ipid_pkg::*;

  logic signed [ERR_W-1:0]   last_err_q, older_err_q;
  logic signed [ERR_W-1:0]   err;
  logic [SPEED_WIDTH-1:0]    mag;
  logic signed [DIFF1_W-1:0] diff1;
  logic signed [DIFF2_W-1:0] diff2;
  logic signed [GAIN_W:0]    gp_s, ki_s, gd_s;
  logic                      separated;
  logic                      take;
  logic                      valid_q;
  prod_t                     prod_q, prod_d;

  // Stage is free when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign prod_o  = prod_q;

  // Error and its magnitude
  assign err = $signed({1'b0, target_speed_i}) - $signed({1'b0, measured_speed_i});
  assign mag = err[ERR_W-1] ? SPEED_WIDTH'(-err) : SPEED_WIDTH'(err);

  // Drop the integral term only when |e| is strictly above the threshold
  assign separated = CMP_W'(mag) > CMP_W'(cfg_i.sep_threshold);

  // First and second error differences
  assign diff1 = err - last_err_q;
  assign diff2 = err - last_err_q - last_err_q + older_err_q;

  assign gp_s = $signed({1'b0, cfg_i.gain_prop});
  assign gd_s = $signed({1'b0, cfg_i.gain_deriv});
  assign ki_s = separated ? '0 : $signed({1'b0, cfg_i.gain_integ});

  // Three independent multiplies
  always_comb begin
    prod_d.prop  = gp_s * diff1;
    prod_d.integ = ki_s * err;
    prod_d.deriv = gd_s * diff2;
  end

  // Advance the error history with each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      older_err_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take) begin
        last_err_q  <= err;
        older_err_q <= last_err_q;
      end
    end
  end

  // Capture the products
  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= prod_d;
    end
  end

endmodule

### src/ipid_accum.sv
// Accumulate and clamp stage: adds the PID terms to the drive value,
// clamps to 0..duty_limit and holds the result for the output channel.
// Depends on ipid_pkg for widths and the prod_t struct.
module ipid_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  ipid_pkg::prod_t               prod_i,
  input  logic [ipid_pkg::DUTY_W-1:0]   duty_limit_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  output logic [ipid_pkg::DUTY_W-1:0]   drive_duty_o,
  input  logic                          out_stall_i
);
  import ipid_pkg::*;

  logic [DUTY_W-1:0]        accum_q, accum_d;
  logic                     valid_q;
  logic                     take;
  logic signed [PROD_W-1:0] p_s, i_s, d_s;
  logic signed [SUM_W-1:0]  sum, lim;

  assign ready_o      = !valid_q || !out_stall_i;
  assign take         = valid_i && ready_o;
  assign out_valid_o  = valid_q;
  assign drive_duty_o = accum_q;

  assign p_s = prod_i.prop;
  assign i_s = prod_i.integ;
  assign d_s = prod_i.deriv;

  // New drive value before clamping
  assign sum = $signed({1'b0, accum_q}) + p_s + i_s + d_s;
  assign lim = $signed({{(SUM_W - DUTY_W){1'b0}}, duty_limit_i});

  // Clamp to the allowed drive range; no reverse drive
  always_comb begin
    if (sum[SUM_W-1]) begin
      accum_d = '0;
    end else if (sum > lim) begin
      accum_d = duty_limit_i;
    end else begin
      accum_d = sum[DUTY_W-1:0];
    end
  end

  // The drive register doubles as the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take) begin
        accum_q <= accum_d;
      end
    end
  end

endmodule

### src/ipid_checker.sv
// Port-level checker for the incremental PID core, bound to the top level.
// Depends on ipid_pkg for widths, register indexes and reset values.
module ipid_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [ipid_pkg::DUTY_W-1:0]        drive_duty_o,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [ipid_pkg::APB_AW-1:0]        paddr,
  input logic [ipid_pkg::APB_DW-1:0]        pwdata,
  input logic                               pready
);
  import ipid_pkg::*;

  logic              in_acc, out_acc, lim_wr;
  logic [1:0]        pend_q, pend_d;
  logic [DUTY_W-1:0] lim_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign lim_wr  = psel && penable && pwrite && pready &&
                   (paddr[APB_AW-1:2] == REG_DUTY_LIMIT);
  assign pend_d  = pend_q + 2'(in_acc) - 2'(out_acc);

  // Track transactions in flight and the programmed duty limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      lim_q  <= DUTY_LIMIT_RESET;
    end else begin
      pend_q <= pend_d;
      if (lim_wr) begin
        lim_q <= pwdata[DUTY_W-1:0];
      end
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_duty_o))
    else $error("stalled result changed");

  // Every accepted transaction reaches the output within the pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ##2 out_valid_o)
    else $error("result missing after input transaction");

  // No result without a pending input, and input stalls only when full
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without input transaction");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pend_q == 2'd3)
    else $error("input stalled with free stages");

  // Drive never exceeds the programmed limit
  a_duty_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_duty_o <= lim_q)
    else $error("drive above duty limit");

endmodule

bind incremental_pid_integral_separation_core ipid_checker u_ipid_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for incremental_pid_integral_separation_core.
// Depends on ipid_pkg and the core RTL; holds its own PID predictor,
// the APB register writer, the input driver and the output checker.
`timescale 1ns / 1ps

module tb_top;
  import ipid_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_PHASES   = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [SPEED_WIDTH-1:0] target_speed_i = '0;
  logic [SPEED_WIDTH-1:0] measured_speed_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [DUTY_W-1:0]      drive_duty_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // Predictor state: register copy, error history and accumulated drive
  cfg_t                     cfg_model;
  logic signed [ERR_W-1:0]  err_last;
  logic signed [ERR_W-1:0]  err_older;
  logic [DUTY_W-1:0]        drive_model;

  logic [DUTY_W-1:0] expected_duty[$];
  int unsigned       mismatch_count = 0;
  bit                gaps_on = 1'b1;
  bit                stall_on = 1'b1;

  incremental_pid_integral_separation_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_speed_i   (target_speed_i),
    .measured_speed_i (measured_speed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_duty_o     (drive_duty_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Clock: 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("incremental_pid_integral_separation_core test failed");
    $finish;
  end

  // Random backpressure on the result channel
  always @(negedge clk_i) begin
    out_stall_i <= stall_on && ($urandom_range(99, 0) < 23);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Compare each completed result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_duty.size() == 0) begin
        report_mismatch($sformatf("unexpected drive_duty %0d", drive_duty_o));
      end else begin
        logic [DUTY_W-1:0] want;
        want = expected_duty.pop_front();
        if (drive_duty_o !== want)
          report_mismatch($sformatf("drive_duty got %0d want %0d", drive_duty_o, want));
      end
    end
  end

  function automatic void reset_pid_model();
    cfg_model = '{gain_prop: '0, gain_integ: '0, gain_deriv: '0,
                  sep_threshold: SEP_THRESHOLD_RESET, duty_limit: DUTY_LIMIT_RESET};
    err_last    = '0;
    err_older   = '0;
    drive_model = '0;
  endfunction

  // Advance the PID model by one sample and queue the duty it produces
  function automatic void pid_model_step(input logic [SPEED_WIDTH-1:0] tgt,
                                         input logic [SPEED_WIDTH-1:0] meas);
    longint err, mag, ki, delta, sum;
    err = longint'(tgt) - longint'(meas);
    mag = (err < 0) ? -err : err;
    // Integral term drops out only when |e| is strictly above the threshold
    ki = (mag > longint'(cfg_model.sep_threshold)) ? 0 : longint'(cfg_model.gain_integ);
    delta = longint'(cfg_model.gain_prop) * (err - longint'(err_last))
          + ki * err
          + longint'(cfg_model.gain_deriv)
            * (err - 2 * longint'(err_last) + longint'(err_older));
    sum = longint'(drive_model) + delta;
    if (sum > longint'(cfg_model.duty_limit)) sum = longint'(cfg_model.duty_limit);
    if (sum < 0) sum = 0;
    drive_model = sum[DUTY_W-1:0];
    err_older   = err_last;
    err_last    = err[ERR_W-1:0];
    expected_duty.push_back(drive_model);
  endfunction

  // Drive one sample transaction; called and returns at a falling edge
  task automatic send_sample(input logic [SPEED_WIDTH-1:0] tgt,
                             input logic [SPEED_WIDTH-1:0] meas);
    while (gaps_on && ($urandom_range(99, 0) < 23)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    target_speed_i   <= tgt;
    measured_speed_i <= meas;
    do @(posedge clk_i); while (in_stall_o);
    pid_model_step(tgt, meas);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_duty.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // APB write: setup then access; an unknown index leaves the model alone
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_GAIN_PROP:     cfg_model.gain_prop     = data[GAIN_W-1:0];
      REG_GAIN_INTEG:    cfg_model.gain_integ    = data[GAIN_W-1:0];
      REG_GAIN_DERIV:    cfg_model.gain_deriv    = data[GAIN_W-1:0];
      REG_SEP_THRESHOLD: cfg_model.sep_threshold = data[THR_W-1:0];
      REG_DUTY_LIMIT:    cfg_model.duty_limit    = data[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Fill the bits above a register's width with noise
  function automatic logic [APB_DW-1:0] with_junk(input logic [APB_DW-1:0] v, input int w);
    return ($urandom() << w) | v;
  endfunction

  task automatic set_all(input int unsigned kp, input int unsigned ki, input int unsigned kd,
                         input int unsigned thr, input int unsigned lim);
    wait_drained();
    set_reg(REG_GAIN_PROP,     with_junk(kp,  GAIN_W));
    set_reg(REG_GAIN_INTEG,    with_junk(ki,  GAIN_W));
    set_reg(REG_GAIN_DERIV,    with_junk(kd,  GAIN_W));
    set_reg(REG_SEP_THRESHOLD, with_junk(thr, THR_W));
    set_reg(REG_DUTY_LIMIT,    with_junk(lim, DUTY_W));
  endtask

  // Reset values: zero gains keep the duty at zero
  task automatic test_reset_values();
    send_sample('1, '0);
    send_sample('0, '1);
    send_sample(16'h1234, 16'h1234);
  endtask

  // Integral term at and just past the separation threshold
  task automatic test_threshold_edge();
    set_all(0, 1, 0, 5, 1023);
    send_sample(16'd105, 16'd100);
    send_sample(16'd106, 16'd100);
    send_sample(16'd94, 16'd100);
    send_sample(16'd95, 16'd100);
    set_all(0, 3, 0, 0, 1023);
    send_sample(16'd7, 16'd7);
    send_sample(16'd8, 16'd7);
  endtask

  // Largest gains and error swings; negative sums clamp at zero
  task automatic test_full_scale();
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1023);
    send_sample('1, '0);
    send_sample('0, '1);
    send_sample('1, '0);
    send_sample('0, '1);
    set_all(2, 0, 0, 16'hFFFF, 1023);
    send_sample(16'd300, 16'd0);
    send_sample(16'd0, 16'd600);
  endtask

  // Lower the limit below the held drive, then limit zero
  task automatic test_limit_lowered();
    set_all(0, 16'hFFFF, 0, 16'hFFFF, 1023);
    send_sample('1, '0);
    set_all(0, 16'hFFFF, 0, 16'hFFFF, 100);
    send_sample('1, '0);
    set_all(0, 16'hFFFF, 0, 16'hFFFF, 0);
    send_sample('1, '0);
  endtask

  // Writes to unused addresses change nothing
  task automatic test_unused_registers();
    wait_drained();
    set_reg(3'd5, '1);
    set_reg(3'd6, '1);
    set_reg(3'd7, '1);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
  endtask

  function automatic int unsigned pick_gain();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 8) return 16'hFFFF;
    if (roll < 16) return 0;
    return $urandom_range(6, 0);
  endfunction

  function automatic int unsigned pick_threshold();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 20) return 16'hFFFF;
    if (roll < 30) return 0;
    return $urandom_range(64, 0);
  endfunction

  function automatic int unsigned pick_limit();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) return 0;
    if (roll < 20) return 1023;
    return $urandom_range(1023, 0);
  endfunction

  // Random phases: mostly small tracking errors, some full-range samples
  task automatic test_random_phases();
    logic [SPEED_WIDTH-1:0] tgt, meas;
    int unsigned roll;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_all(pick_gain(), pick_gain(), pick_gain(), pick_threshold(), pick_limit());
      // Phase 3 runs back to back with no gaps and no stalls
      gaps_on  = (ph != 3);
      stall_on = (ph != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99, 0);
        tgt  = SPEED_WIDTH'($urandom());
        if (roll < 15) meas = SPEED_WIDTH'($urandom());
        else if (roll < 20) meas = tgt;
        else meas = tgt + SPEED_WIDTH'($urandom_range(64, 0)) - SPEED_WIDTH'(32);
        send_sample(tgt, meas);
      end
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    reset_pid_model();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_threshold_edge();
    test_full_scale();
    test_limit_lowered();
    test_unused_registers();
    test_random_phases();

    wait_drained();
    if (mismatch_count == 0 && expected_duty.size() == 0) begin
      $display("incremental_pid_integral_separation_core test passed");
    end else begin
      $display("incremental_pid_integral_separation_core test failed");
    end
    $finish;
  end

endmodule
